>>> sv/lrce_pkg.sv
// Package for the lane run center extractor: sizes, register indexes and
// the request and response payload structs. No dependencies.
package lrce_pkg;

   // Mask geometry limits.
   localparam int MAX_COLS = 1024;
   localparam int MAX_ROWS = 512;
   localparam int COL_W    = $clog2(MAX_COLS);
   localparam int ROW_W    = $clog2(MAX_ROWS);

   // Field and register widths.
   localparam int SCORE_W = 16;
   localparam int MRW_W   = 11;
   localparam int RL_W    = 11;
   localparam int RC_W    = 10;
   localparam int SCALE_W = 16;
   localparam int FRAC_W  = 12;
   localparam int U_W     = 14;
   localparam int V_W     = 13;
   localparam int U_MAX   = 16383;
   localparam int V_MAX   = 8191;

   // Configuration port.
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 16;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_SCORE_THRESHOLD = 3'd0,
      CSR_MAX_RUN_WIDTH   = 3'd1,
      CSR_ROW_LENGTH      = 3'd2,
      CSR_ROW_COUNT       = 3'd3,
      CSR_SCALE_X         = 3'd4,
      CSR_SCALE_Y         = 3'd5
   } csr_index_type;

   // Register values after reset.
   localparam logic [SCORE_W-1:0] THRESHOLD_RST = 16'd32768;
   localparam logic [MRW_W-1:0]   MRW_RST       = 11'd30;
   localparam logic [RL_W-1:0]    RL_RST        = 11'd512;
   localparam logic [RC_W-1:0]    RC_RST        = 10'd288;
   localparam logic [SCALE_W-1:0] SCALE_RST     = 16'd10240;

   typedef struct packed {
      logic [SCORE_W-1:0] lane_score;
      logic               frame_start;
   } req_type;

   typedef struct packed {
      logic [U_W-1:0] center_u;
      logic [V_W-1:0] row_v;
   } rsp_type;

endpackage

>>> sv/lane_run_center_extractor_core.sv
// Top level of the lane run center extractor.
// Depends on lrce_pkg for sizes, register indexes and payload structs.

// The block takes one pixel score per clock in raster order, while requests
// are not stalled, and emits the scaled center column and row of every short
// run of set pixels that closes within its row. Run tracking and position
// counters update in the cycle a request is accepted; the run center then
// passes a register stage and the two Q4.12 scale multipliers before
// reaching the output register.
// Request stall rises only while a result waits in the output register and
// the stage behind it is also full. Configuration writes are always ready
// and must only be made while no request is in flight.
module lane_run_center_extractor_core (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  lrce_pkg::req_type             req_data,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output lrce_pkg::rsp_type             rsp_data,
   input  logic                          csr_valid,
   output logic                          csr_ready,
   input  logic [lrce_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [lrce_pkg::CSR_DATA_W-1:0] csr_data
);

   localparam int COL_W   = lrce_pkg::COL_W;
   localparam int ROW_W   = lrce_pkg::ROW_W;
   localparam int RL_W    = lrce_pkg::RL_W;
   localparam int RC_W    = lrce_pkg::RC_W;
   localparam int MRW_W   = lrce_pkg::MRW_W;
   localparam int SCALE_W = lrce_pkg::SCALE_W;
   localparam int FRAC_W  = lrce_pkg::FRAC_W;
   localparam int PU_W    = COL_W + SCALE_W;
   localparam int PV_W    = ROW_W + SCALE_W;

   // Configuration registers.
   logic [lrce_pkg::SCORE_W-1:0] threshold_ff;
   logic [MRW_W-1:0]             max_run_width_ff;
   logic [RL_W-1:0]              row_length_ff;
   logic [RC_W-1:0]              row_count_ff;
   logic [SCALE_W-1:0]           scale_x_ff;
   logic [SCALE_W-1:0]           scale_y_ff;

   // Position and run state.
   logic [COL_W-1:0] column_ff, column_in;
   logic [ROW_W-1:0] row_ff, row_in;
   logic             run_open_ff, run_open_in;
   logic [COL_W-1:0] run_begin_ff, run_begin_in;

   // Center stage and output register.
   logic             a_valid_ff, a_valid_in;
   logic [COL_W-1:0] a_center_ff;
   logic [ROW_W-1:0] a_row_ff;
   logic             rsp_valid_ff, rsp_valid_in;
   lrce_pkg::rsp_type rsp_data_ff;

   logic             req_accept;
   logic             b_take;
   logic             a_take;
   logic [COL_W-1:0] col_cur;
   logic [ROW_W-1:0] row_cur;
   logic             open_cur;
   logic             pixel_set;
   logic [COL_W-1:0] run_width;
   logic [COL_W-1:0] center;
   logic             emit;
   logic [RL_W-1:0]  rl_eff;
   logic [RC_W-1:0]  rc_eff;
   logic             row_end;
   logic [PU_W-1:0]  prod_u;
   logic [PV_W-1:0]  prod_v;
   logic [PU_W-FRAC_W-1:0] shifted_u;
   logic [PV_W-FRAC_W-1:0] shifted_v;
   lrce_pkg::rsp_type scaled;

   // Handshake: the output register drains or refills, the center stage
   // moves on when it is empty or the output register takes it.
   assign b_take     = !rsp_valid_ff || !rsp_stall;
   assign a_take     = !a_valid_ff || b_take;
   assign req_stall  = !a_take;
   assign req_accept = req_valid && a_take;
   assign csr_ready  = 1'b1;

   // Configuration writes; indexes beyond the list are ignored.
   always_ff @(posedge clock) begin
      if (reset) begin
         threshold_ff     <= lrce_pkg::THRESHOLD_RST;
         max_run_width_ff <= lrce_pkg::MRW_RST;
         row_length_ff    <= lrce_pkg::RL_RST;
         row_count_ff     <= lrce_pkg::RC_RST;
         scale_x_ff       <= lrce_pkg::SCALE_RST;
         scale_y_ff       <= lrce_pkg::SCALE_RST;
      end else if (csr_valid) begin
         case (csr_index)
            lrce_pkg::CSR_SCORE_THRESHOLD: threshold_ff     <= csr_data;
            lrce_pkg::CSR_MAX_RUN_WIDTH:   max_run_width_ff <= csr_data[MRW_W-1:0];
            lrce_pkg::CSR_ROW_LENGTH:      row_length_ff    <= csr_data[RL_W-1:0];
            lrce_pkg::CSR_ROW_COUNT:       row_count_ff     <= csr_data[RC_W-1:0];
            lrce_pkg::CSR_SCALE_X:         scale_x_ff       <= csr_data;
            lrce_pkg::CSR_SCALE_Y:         scale_y_ff       <= csr_data;
            default: ;
         endcase
      end
   end

   // Effective row length and row count: zero counts as one, and values
   // above the mask limits saturate.
   always_comb begin
      if (row_length_ff == '0) begin
         rl_eff = RL_W'(1);
      end else if (row_length_ff > RL_W'(lrce_pkg::MAX_COLS)) begin
         rl_eff = RL_W'(lrce_pkg::MAX_COLS);
      end else begin
         rl_eff = row_length_ff;
      end
      if (row_count_ff == '0) begin
         rc_eff = RC_W'(1);
      end else if (row_count_ff > RC_W'(lrce_pkg::MAX_ROWS)) begin
         rc_eff = RC_W'(lrce_pkg::MAX_ROWS);
      end else begin
         rc_eff = row_count_ff;
      end
   end

   // Run tracking for the pixel on the request port.
   always_comb begin
      col_cur   = req_data.frame_start ? '0 : column_ff;
      row_cur   = req_data.frame_start ? '0 : row_ff;
      open_cur  = req_data.frame_start ? 1'b0 : run_open_ff;
      pixel_set = req_data.lane_score > threshold_ff;
      run_width = col_cur - run_begin_ff;
      center    = run_begin_ff + (run_width >> 1);
      emit      = !pixel_set && open_cur && (MRW_W'(run_width) <= max_run_width_ff);
      row_end   = (RL_W'(col_cur) + RL_W'(1)) >= rl_eff;

      run_begin_in = (pixel_set && !open_cur) ? col_cur : run_begin_ff;
      if (row_end) begin
         column_in   = '0;
         run_open_in = 1'b0;
         if ((RC_W'(row_cur) + RC_W'(1)) >= rc_eff) begin
            row_in = '0;
         end else begin
            row_in = row_cur + ROW_W'(1);
         end
      end else begin
         column_in   = col_cur + COL_W'(1);
         run_open_in = pixel_set;
         row_in      = row_cur;
      end
   end

   // State registers advance on each accepted request.
   always_ff @(posedge clock) begin
      if (reset) begin
         column_ff    <= '0;
         row_ff       <= '0;
         run_open_ff  <= 1'b0;
         run_begin_ff <= '0;
      end else if (req_accept) begin
         column_ff    <= column_in;
         row_ff       <= row_in;
         run_open_ff  <= run_open_in;
         run_begin_ff <= run_begin_in;
      end
   end

   // Center stage holds a closed run until the output register takes it.
   assign a_valid_in = a_take ? (req_accept && emit) : a_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
      end else begin
         a_valid_ff <= a_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (a_take && req_accept && emit) begin
         a_center_ff <= center;
         a_row_ff    <= row_cur;
      end
   end

   // Scale the center and row by the Q4.12 factors, truncate and saturate.
   always_comb begin
      prod_u    = PU_W'(a_center_ff) * PU_W'(scale_x_ff);
      prod_v    = PV_W'(a_row_ff) * PV_W'(scale_y_ff);
      shifted_u = prod_u[PU_W-1:FRAC_W];
      shifted_v = prod_v[PV_W-1:FRAC_W];
      if (shifted_u > (PU_W-FRAC_W)'(lrce_pkg::U_MAX)) begin
         scaled.center_u = lrce_pkg::U_W'(lrce_pkg::U_MAX);
      end else begin
         scaled.center_u = lrce_pkg::U_W'(shifted_u);
      end
      if (shifted_v > (PV_W-FRAC_W)'(lrce_pkg::V_MAX)) begin
         scaled.row_v = lrce_pkg::V_W'(lrce_pkg::V_MAX);
      end else begin
         scaled.row_v = lrce_pkg::V_W'(shifted_v);
      end
   end

   // Output register.
   assign rsp_valid_in = b_take ? a_valid_ff : rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (b_take && a_valid_ff) begin
         rsp_data_ff <= scaled;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

>>> sv/lrce_checker.sv
// Port-level checker for lane_run_center_extractor_core, bound to it below.
// Depends on lrce_pkg for the response payload struct.
module lrce_checker (
   input logic                            clock,
   input logic                            reset,
   input logic                            req_valid,
   input logic                            req_stall,
   input logic                            rsp_valid,
   input logic                            rsp_stall,
   input lrce_pkg::rsp_type               rsp_data
);

   // A stalled response keeps its valid and its payload.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("stalled response changed");

   // Reset empties the output register.
   assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("response valid right after reset");

   // From an empty output register, a response only appears after an accepted request has passed the center stage.
   assert property (@(posedge clock) disable iff (reset)
      !rsp_valid && !$past(req_valid && !req_stall) |=> !rsp_valid)
      else $error("response appeared without a request");

   // Requests are held back only while the response side is backed up.
   assert property (@(posedge clock) disable iff (reset)
      req_stall |-> rsp_valid && rsp_stall)
      else $error("request stalled with response side free");

endmodule

bind lane_run_center_extractor_core lrce_checker u_lrce_checker (.*);
